>>> rtl/price_level_book_bbo_defines.svh
// Assertion macros used by the checks in the top-level file of this block
`ifndef PRICE_LEVEL_BOOK_BBO_DEFINES_SVH
`define PRICE_LEVEL_BOOK_BBO_DEFINES_SVH

// same-cycle implication
`define PLBB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbl violated");

// next-cycle implication
`define PLBB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbl violated");

`endif

>>> rtl/plbb_pkg.sv
package plbb_pkg;

   localparam int PRICE_W    = 12;
   localparam int SIZE_OUT_W = 31;

   // error codes
   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_PRICE    = 2'd1;
   localparam logic [1:0] ERR_SIZE     = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   // book status codes
   localparam logic [1:0] BOOK_EMPTY   = 2'd0;
   localparam logic [1:0] BOOK_LIVE    = 2'd1;
   localparam logic [1:0] BOOK_CROSSED = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WIPE,
      ST_APPLY_RD,
      ST_APPLY_WR,
      ST_SCAN,
      ST_SCAN_END,
      ST_RESULT
   } state_type;

endpackage

>>> rtl/plbb_front.sv
module plbb_front #(
   parameter int PRICE_LEVELS = 4096,
   parameter int BATCH_MAX    = 64,
   parameter int QTY_BITS     = 31,
   localparam int PLB = $clog2(PRICE_LEVELS),
   localparam int BIW = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1,
   localparam int CW  = $clog2(BATCH_MAX + 1),
   localparam int EW  = 1 + PLB + QTY_BITS,
   localparam int QW  = CW + 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_cmd,
   input  logic                  req_side,
   input  logic [15:0]           req_price,
   input  logic [31:0]           req_size,
   input  logic                  req_last,
   input  logic                  req_empty,
   input  logic [plbb_pkg::PRICE_W-1:0] price_min,
   input  logic [plbb_pkg::PRICE_W-1:0] price_max,
   input  logic                  block,
   input  logic                  batch_done,
   output logic                  push_valid,
   output logic [QW-1:0]         push_data,
   input  logic [BIW-1:0]        rd_addr,
   output logic [EW-1:0]         rd_data
);

   localparam logic [63:0] QMAX = (64'd1 << QTY_BITS) - 64'd1;

   logic [EW-1:0]  pend_mem [BATCH_MAX];
   logic [CW-1:0]  count_ff, count_in;
   logic [1:0]     err_ff, err_in;
   logic           busy_ff, busy_in;
   logic [EW-1:0]  rd_data_ff;
   logic           fire, full, px_ok, wr_en;
   logic [1:0]     ent_err;
   logic [63:0]    q64, qsat;

   assign req_tready = !busy_ff && !block;
   assign fire       = req_tvalid && req_tready;
   assign full       = count_ff >= CW'(BATCH_MAX);

   // entry check: price range first, then sign
   assign px_ok = ({1'b0, req_price} >= {5'd0, price_min}) &&
                  ({1'b0, req_price} <= {5'd0, price_max}) &&
                  ({1'b0, req_price} < 17'(PRICE_LEVELS));
   assign q64   = {33'd0, req_size[30:0]};
   assign qsat  = (q64 > QMAX) ? QMAX : q64;

   always_comb begin
      ent_err  = !px_ok ? plbb_pkg::ERR_PRICE :
                 req_size[31] ? plbb_pkg::ERR_SIZE : plbb_pkg::ERR_OK;
      wr_en    = 1'b0;
      count_in = count_ff;
      err_in   = err_ff;
      if (fire && !req_empty) begin
         if (full) begin
            if (err_ff == plbb_pkg::ERR_OK) err_in = plbb_pkg::ERR_OVERFLOW;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
            if (err_ff == plbb_pkg::ERR_OK) err_in = ent_err;
         end
      end
      busy_in = busy_ff;
      if (batch_done) busy_in = 1'b0;
      if (fire && req_last) busy_in = 1'b1;
   end

   // hand the closed batch to the back end
   assign push_valid = fire && req_last;
   assign push_data  = {count_in, err_in, req_cmd};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= plbb_pkg::ERR_OK;
         busy_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (fire && req_last) begin
            count_ff <= '0;
            err_ff   <= plbb_pkg::ERR_OK;
         end else begin
            count_ff <= count_in;
            err_ff   <= err_in;
         end
      end
   end

   // pending entry buffer
   always_ff @(posedge clock) begin
      if (wr_en)
         pend_mem[count_ff[BIW-1:0]] <= {req_side, PLB'(req_price), QTY_BITS'(qsat)};
      rd_data_ff <= pend_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/plbb_queue.sv
module plbb_queue #(
   parameter int W = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic         not_empty,
   output logic [W-1:0] head
);

   logic [W-1:0] slot_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   fill_ff;

   assign not_empty = fill_ff != 2'd0;
   assign head      = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push && fill_ff != 2'd2) wp_ff <= !wp_ff;
         if (pop && not_empty) rp_ff <= !rp_ff;
         fill_ff <= fill_ff + 2'((push && fill_ff != 2'd2) ? 1 : 0)
                            - 2'((pop && not_empty) ? 1 : 0);
      end
   end

   always_ff @(posedge clock) begin
      if (push && fill_ff != 2'd2) slot_ff[wp_ff] <= push_data;
   end

endmodule

>>> rtl/plbb_back.sv
module plbb_back #(
   parameter int PRICE_LEVELS = 4096,
   parameter int BATCH_MAX    = 64,
   parameter int QTY_BITS     = 31,
   localparam int PLB = $clog2(PRICE_LEVELS),
   localparam int BIW = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1,
   localparam int CW  = $clog2(BATCH_MAX + 1),
   localparam int EW  = 1 + PLB + QTY_BITS,
   localparam int QW  = CW + 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [plbb_pkg::PRICE_W-1:0] price_min,
   input  logic [plbb_pkg::PRICE_W-1:0] price_max,
   input  logic                  q_not_empty,
   input  logic [QW-1:0]         q_head,
   output logic                  q_pop,
   output logic [BIW-1:0]        pend_addr,
   input  logic [EW-1:0]         pend_data,
   output logic                  clearing,
   output logic                  batch_done,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [95:0]           rsp_tdata
);

   plbb_pkg::state_type state_ff, state_in;

   logic [QTY_BITS-1:0] bid_mem [PRICE_LEVELS];
   logic [QTY_BITS-1:0] ask_mem [PRICE_LEVELS];
   logic [QTY_BITS-1:0] bid_rd_ff, ask_rd_ff;

   logic [PLB-1:0]      addr_ff, addr_in;
   logic [PLB-1:0]      rd_addr_ff;
   logic                rd_vld_ff, rd_vld_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [1:0]          err_ff;
   logic [CW-1:0]       cnt_ff;

   logic                has_bid_ff, has_ask_ff;
   logic [PLB-1:0]      bid_px_ff, ask_px_ff;
   logic [QTY_BITS-1:0] bid_qty_ff, ask_qty_ff;
   logic                quote_clr;

   logic                rsp_valid_ff;
   logic [95:0]         rsp_data_ff;

   logic                we_clr, we_bid, we_ask, load_rsp;
   logic [PLB-1:0]      mem_addr;
   logic [16:0]         hi_ext;
   logic                range_ok;
   logic [PLB-1:0]      lo, hi;
   logic                p_side;
   logic [PLB-1:0]      p_px;
   logic [QTY_BITS-1:0] p_qty;
   logic [1:0]          status;

   // searched range, clipped to the ladder depth
   assign hi_ext   = ({5'd0, price_max} > 17'(PRICE_LEVELS - 1)) ?
                     17'(PRICE_LEVELS - 1) : {5'd0, price_max};
   assign range_ok = {5'd0, price_min} <= hi_ext;
   assign lo       = PLB'(price_min);
   assign hi       = PLB'(hi_ext);

   assign p_side = pend_data[EW-1];
   assign p_px   = pend_data[EW-2 -: PLB];
   assign p_qty  = pend_data[QTY_BITS-1:0];

   assign pend_addr = idx_ff[BIW-1:0];
   assign clearing  = state_ff == plbb_pkg::ST_CLEAR;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= plbb_pkg::ST_CLEAR;
      else       state_ff <= state_in;
   end

   // sequencer: next state and strobes
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      idx_in     = idx_ff;
      rd_vld_in  = 1'b0;
      q_pop      = 1'b0;
      we_clr     = 1'b0;
      we_bid     = 1'b0;
      we_ask     = 1'b0;
      quote_clr  = 1'b0;
      load_rsp   = 1'b0;
      batch_done = 1'b0;
      mem_addr   = addr_ff;
      case (state_ff)
         plbb_pkg::ST_CLEAR: begin
            we_clr  = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == PLB'(PRICE_LEVELS - 1)) begin
               addr_in  = '0;
               state_in = plbb_pkg::ST_IDLE;
            end
         end
         plbb_pkg::ST_IDLE: begin
            if (q_not_empty) begin
               q_pop   = 1'b1;
               addr_in = '0;
               idx_in  = '0;
               if (q_head[0])
                  state_in = plbb_pkg::ST_WIPE;
               else if (q_head[2:1] != plbb_pkg::ERR_OK)
                  state_in = plbb_pkg::ST_RESULT;
               else if (q_head[QW-1:3] == '0)
                  state_in = plbb_pkg::ST_SCAN;
               else
                  state_in = plbb_pkg::ST_APPLY_RD;
               // a snapshot sweeps the whole ladder from level zero
               if (!q_head[0] && q_head[2:1] == plbb_pkg::ERR_OK) addr_in = lo;
            end
         end
         plbb_pkg::ST_WIPE: begin
            we_clr    = 1'b1;
            quote_clr = 1'b1;
            addr_in   = addr_ff + 1'b1;
            if (addr_ff == PLB'(PRICE_LEVELS - 1)) begin
               addr_in = lo;
               if (err_ff != plbb_pkg::ERR_OK) state_in = plbb_pkg::ST_RESULT;
               else if (cnt_ff == '0)          state_in = plbb_pkg::ST_SCAN;
               else                            state_in = plbb_pkg::ST_APPLY_RD;
            end
         end
         plbb_pkg::ST_APPLY_RD: begin
            state_in = plbb_pkg::ST_APPLY_WR;
         end
         plbb_pkg::ST_APPLY_WR: begin
            mem_addr = p_px;
            we_bid   = !p_side;
            we_ask   = p_side;
            idx_in   = idx_ff + 1'b1;
            if (CW'(idx_ff + 1'b1) == cnt_ff) state_in = plbb_pkg::ST_SCAN;
            else                              state_in = plbb_pkg::ST_APPLY_RD;
         end
         plbb_pkg::ST_SCAN: begin
            // first cycle of the scan also clears the quote
            if (!rd_vld_ff) quote_clr = 1'b1;
            if (!range_ok) begin
               state_in = plbb_pkg::ST_RESULT;
            end else begin
               rd_vld_in = 1'b1;
               addr_in   = addr_ff + 1'b1;
               if (addr_ff == hi) state_in = plbb_pkg::ST_SCAN_END;
            end
         end
         plbb_pkg::ST_SCAN_END: begin
            state_in = plbb_pkg::ST_RESULT;
         end
         plbb_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp   = 1'b1;
               batch_done = 1'b1;
               state_in   = plbb_pkg::ST_IDLE;
            end
         end
         default: state_in = plbb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= '0;
         idx_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         has_bid_ff <= 1'b0;
         has_ask_ff <= 1'b0;
      end else begin
         addr_ff   <= addr_in;
         idx_ff    <= idx_in;
         rd_vld_ff <= rd_vld_in;
         if (quote_clr) begin
            has_bid_ff <= 1'b0;
            has_ask_ff <= 1'b0;
         end else if (rd_vld_ff) begin
            if (bid_rd_ff != '0) has_bid_ff <= 1'b1;
            if (ask_rd_ff != '0) has_ask_ff <= 1'b1;
         end
      end
   end

   // batch descriptor and quote payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         err_ff  <= q_head[2:1];
         cnt_ff  <= q_head[QW-1:3];
      end
      rd_addr_ff <= mem_addr;
      if (rd_vld_ff && !quote_clr) begin
         // ascending scan: last nonzero bid is the highest
         if (bid_rd_ff != '0) begin
            bid_px_ff  <= rd_addr_ff;
            bid_qty_ff <= bid_rd_ff;
         end
         if (ask_rd_ff != '0 && !has_ask_ff) begin
            ask_px_ff  <= rd_addr_ff;
            ask_qty_ff <= ask_rd_ff;
         end
      end
   end

   // ladders
   always_ff @(posedge clock) begin
      if (we_clr || we_bid) bid_mem[mem_addr] <= we_clr ? '0 : p_qty;
      if (we_clr || we_ask) ask_mem[mem_addr] <= we_clr ? '0 : p_qty;
      bid_rd_ff <= bid_mem[mem_addr];
      ask_rd_ff <= ask_mem[mem_addr];
   end

   assign status = (has_bid_ff && has_ask_ff) ?
                   ((bid_px_ff >= ask_px_ff) ? plbb_pkg::BOOK_CROSSED : plbb_pkg::BOOK_LIVE) :
                   (has_bid_ff || has_ask_ff) ? plbb_pkg::BOOK_LIVE : plbb_pkg::BOOK_EMPTY;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_rsp)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp)
         rsp_data_ff <= {4'd0, status, has_ask_ff,
                         has_ask_ff ? plbb_pkg::SIZE_OUT_W'(ask_qty_ff) : '0,
                         has_ask_ff ? plbb_pkg::PRICE_W'(ask_px_ff) : '0,
                         has_bid_ff,
                         has_bid_ff ? plbb_pkg::SIZE_OUT_W'(bid_qty_ff) : '0,
                         has_bid_ff ? plbb_pkg::PRICE_W'(bid_px_ff) : '0,
                         err_ff};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/price_level_book_bbo.sv
// Price-level order book with best bid and offer.
// req_ carries level entries (side, price, size); tlast closes a batch and
// tuser gives the batch kind (change set or snapshot) and an empty-entry flag.
// Entries are taken one word per cycle, while req_tready is high, into a
// pending buffer. A closing word hands the batch to the back end and
// req_tready drops until its result is loaded into the output register.
// Back end steps per batch: take it from the queue, wipe the whole ladder for
// a snapshot, read and then write each buffered entry, scan the ladder with
// one read per level from price_min to price_max plus a drain state (an empty
// range skips the scan), then load the output register.
// A rejected batch skips apply and scan; a rejected change set goes from the
// queue straight to its result stage.
// rsp_ returns one word per closing word: error code, best bid/ask with
// sizes and present flags, and the book status.
// After reset the ladders are cleared by a sweep over every price level,
// during which req_tready stays low. A stalled rsp_tready holds the result
// in the output register; the next batch may buffer meanwhile and waits
// only at its result stage.
`include "price_level_book_bbo_defines.svh"

module price_level_book_bbo #(
   parameter int PRICE_LEVELS = 4096,
   parameter int BATCH_MAX    = 64,
   parameter int QTY_BITS     = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // side, level_price[16], level_size[32]
   input  logic [1:0]  req_tuser,   // cmd, empty_batch
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // error_code[2], bid_price[12], bid_size[31], bid_present,
   // ask_price[12], ask_size[31], ask_present, book_status[2]
   output logic [95:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int PLB = $clog2(PRICE_LEVELS);
   localparam int BIW = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
   localparam int CW  = $clog2(BATCH_MAX + 1);
   localparam int EW  = 1 + PLB + QTY_BITS;
   localparam int QW  = CW + 3;

   localparam logic CSR_PRICE_MIN = 1'b0;
   localparam logic CSR_PRICE_MAX = 1'b1;

   logic [11:0]    price_min_ff, price_max_ff;
   logic           push_valid, q_pop, q_not_empty, clearing, batch_done;
   logic [QW-1:0]  push_data, q_head;
   logic [BIW-1:0] pend_addr;
   logic [EW-1:0]  pend_data;
   logic           close_fire, rsp_crossed, rsp_both, rsp_no_bid, rsp_bid_zero;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         price_min_ff <= 12'd0;
         price_max_ff <= 12'd4095;
      end else if (csr_we) begin
         if (csr_index == CSR_PRICE_MIN) price_min_ff <= csr_wdata;
         if (csr_index == CSR_PRICE_MAX) price_max_ff <= csr_wdata;
      end
   end

   plbb_front #(
      .PRICE_LEVELS(PRICE_LEVELS), .BATCH_MAX(BATCH_MAX), .QTY_BITS(QTY_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser[0]),
      .req_side   (req_tdata[0]),
      .req_price  (req_tdata[16:1]),
      .req_size   (req_tdata[48:17]),
      .req_last   (req_tlast),
      .req_empty  (req_tuser[1]),
      .price_min  (price_min_ff),
      .price_max  (price_max_ff),
      .block      (clearing),
      .batch_done (batch_done),
      .push_valid (push_valid),
      .push_data  (push_data),
      .rd_addr    (pend_addr),
      .rd_data    (pend_data)
   );

   plbb_queue #(.W(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   plbb_back #(
      .PRICE_LEVELS(PRICE_LEVELS), .BATCH_MAX(BATCH_MAX), .QTY_BITS(QTY_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .price_min   (price_min_ff),
      .price_max   (price_max_ff),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .pend_addr   (pend_addr),
      .pend_data   (pend_data),
      .clearing    (clearing),
      .batch_done  (batch_done),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // checks
   assign close_fire   = req_tvalid && req_tready && req_tlast;
   assign rsp_crossed  = rsp_tvalid && rsp_tdata[91:90] == plbb_pkg::BOOK_CROSSED;
   assign rsp_both     = rsp_tdata[45] && rsp_tdata[89];
   assign rsp_no_bid   = rsp_tvalid && !rsp_tdata[45];
   assign rsp_bid_zero = rsp_tdata[44:2] == '0;

   `PLBB_ASSERT_NEXT(a_close_blocks, clock, reset, close_fire, !req_tready)
   `PLBB_ASSERT_NOW(a_crossed_both, clock, reset, rsp_crossed, rsp_both)
   `PLBB_ASSERT_NOW(a_no_bid_zero, clock, reset, rsp_no_bid, rsp_bid_zero)

endmodule
